FILE: hdl/sled_pkg.sv
// Shared types and constants for the string literal escape decoder.
package sled_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LEN_W         = 16;
    localparam int unsigned QUEUE_DEPTH_D = 4;

    // Result kinds.
    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_END_QUOTE = 2'd1;
    localparam logic [1:0] KIND_END_EOL   = 2'd2;

    // Warning codes.
    localparam logic [1:0] WARN_NONE      = 2'd0;
    localparam logic [1:0] WARN_UNKNOWN   = 2'd1;
    localparam logic [1:0] WARN_NOT_HEX   = 2'd2;
    localparam logic [1:0] WARN_HEX_RANGE = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_EOL       = 8'h00;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_VT        = 8'h0B;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_V     = 8'h76;
    localparam logic [7:0] CH_LOW_X     = 8'h78;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [1:0]       warn;
        logic [LEN_W-1:0] len;
    } t_res;

    // All results caused by one input byte.
    typedef struct packed {
        t_res first;
        t_res second;
        logic two;
        logic consumed;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_push;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_head;

endpackage

FILE: hdl/sled_front.sv
// Front end: accepts bytes, runs the escape state machine and builds result records.
module sled_front
    import sled_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_start_string,
    input  logic        i_queue_full,
    output t_push       o_push
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_TEXT  = 3'd1,
        MODE_ESC   = 3'd2,
        MODE_OCT   = 3'd3,
        MODE_HEX1  = 3'd4,
        MODE_HEX   = 3'd5,
        MODE_QUOTE = 3'd6
    } t_mode;

    t_mode            r_mode, n_mode, m;
    logic [7:0]       r_esc, n_esc, ev;
    logic [1:0]       r_oct, n_oct, oc, oc_inc;
    logic             r_hov, n_hov, ho;
    logic [LEN_W-1:0] r_len, n_len, ln, len_a;
    logic             accept;

    logic             pre_v, txt_v, use_text, consumed;
    logic [1:0]       pre_kind, pre_warn, txt_kind;
    logic [7:0]       pre_data, txt_data, b;
    logic             hex_ok;
    logic [3:0]       hex_nib;
    t_res             res_pre, res_txt;

    function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v,
                                                 input logic [1:0] kind);
        logic [LEN_W-1:0] r;
        r = v;
        if (kind == KIND_DATA && v != {LEN_W{1'b1}}) begin
            r = v + LEN_W'(1);
        end
        return r;
    endfunction

    assign b       = i_byte_value;
    assign accept  = i_valid && !o_stall;
    assign o_stall = i_queue_full;

    always_comb begin
        hex_ok  = 1'b1;
        hex_nib = b[3:0];
        if (b inside {[8'h30:8'h39]}) begin
            hex_nib = b[3:0];
        end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_nib = 4'(b[2:0] + 3'd1) + 4'd8;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        m  = i_start_string ? MODE_TEXT : r_mode;
        ev = i_start_string ? 8'd0 : r_esc;
        oc = i_start_string ? 2'd0 : r_oct;
        ho = i_start_string ? 1'b0 : r_hov;
        ln = i_start_string ? '0 : r_len;
        oc_inc = 2'(oc + 2'd1);

        n_mode   = m;
        n_esc    = ev;
        n_oct    = oc;
        n_hov    = ho;
        pre_v    = 1'b0;
        pre_kind = KIND_DATA;
        pre_data = 8'd0;
        pre_warn = WARN_NONE;
        use_text = 1'b0;
        consumed = 1'b1;
        txt_v    = 1'b0;
        txt_kind = KIND_DATA;
        txt_data = 8'd0;

        case (m)
            MODE_TEXT: begin
                use_text = 1'b1;
            end
            MODE_ESC: begin
                n_mode = MODE_TEXT;
                if (b inside {[8'h30:8'h37]}) begin
                    n_esc  = {5'd0, b[2:0]};
                    n_oct  = 2'd1;
                    n_mode = MODE_OCT;
                end else begin
                    pre_v    = 1'b1;
                    pre_data = b;
                    case (b)
                        CH_LOW_X: begin
                            pre_v  = 1'b0;
                            n_esc  = 8'd0;
                            n_hov  = 1'b0;
                            n_mode = MODE_HEX1;
                        end
                        CH_LOW_A: pre_data = CH_BEL;
                        CH_LOW_B: pre_data = CH_BS;
                        CH_LOW_F: pre_data = CH_FF;
                        CH_LOW_N: pre_data = CH_LF;
                        CH_LOW_R: pre_data = CH_CR;
                        CH_LOW_T: pre_data = CH_TAB;
                        CH_LOW_V: pre_data = CH_VT;
                        CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK: pre_data = b;
                        default: begin
                            // Unknown escape: the character itself, and a backslash
                            // right before end of line still ends the string.
                            pre_warn = WARN_UNKNOWN;
                            use_text = (b == CH_EOL);
                        end
                    endcase
                end
            end
            MODE_OCT: begin
                if (b inside {[8'h30:8'h37]}) begin
                    n_esc = {ev[4:0], b[2:0]};
                    n_oct = oc_inc;
                    if (oc_inc == 2'd3) begin
                        pre_v    = 1'b1;
                        pre_data = {ev[4:0], b[2:0]};
                        n_mode   = MODE_TEXT;
                        n_oct    = 2'd0;
                    end
                end else begin
                    pre_v    = 1'b1;
                    pre_data = ev;
                    n_oct    = 2'd0;
                    use_text = 1'b1;
                end
            end
            MODE_HEX1: begin
                if (hex_ok) begin
                    n_esc  = {4'd0, hex_nib};
                    n_hov  = 1'b0;
                    n_mode = MODE_HEX;
                end else begin
                    pre_v    = 1'b1;
                    pre_data = CH_LOW_X;
                    pre_warn = WARN_NOT_HEX;
                    use_text = 1'b1;
                end
            end
            MODE_HEX: begin
                if (hex_ok) begin
                    if (|ev[7:4]) begin
                        n_hov = 1'b1;
                    end
                    n_esc = {ev[3:0], hex_nib};
                end else begin
                    pre_v    = 1'b1;
                    pre_data = ev;
                    pre_warn = ho ? WARN_HEX_RANGE : WARN_NONE;
                    n_hov    = 1'b0;
                    use_text = 1'b1;
                end
            end
            MODE_QUOTE: begin
                pre_v = 1'b1;
                if (b == CH_DQUOTE) begin
                    pre_data = CH_DQUOTE;
                    n_mode   = MODE_TEXT;
                end else begin
                    consumed = 1'b0;
                    pre_kind = KIND_END_QUOTE;
                    n_mode   = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        if (use_text) begin
            case (b)
                CH_EOL: begin
                    txt_v    = 1'b1;
                    txt_kind = KIND_END_EOL;
                    consumed = 1'b0;
                    n_mode   = MODE_IDLE;
                end
                CH_DQUOTE:    n_mode = MODE_QUOTE;
                CH_BACKSLASH: n_mode = MODE_ESC;
                default: begin
                    txt_v    = 1'b1;
                    txt_data = b;
                    n_mode   = MODE_TEXT;
                end
            endcase
        end

        len_a = pre_v ? sat_inc(ln, pre_kind) : ln;
        n_len = txt_v ? sat_inc(len_a, txt_kind) : len_a;

        res_pre = '{kind: pre_kind, data: pre_data, warn: pre_warn, len: len_a};
        res_txt = '{kind: txt_kind, data: txt_data, warn: WARN_NONE, len: n_len};

        o_push.valid        = accept && (pre_v || txt_v);
        o_push.rec.consumed = consumed;
        o_push.rec.two      = pre_v && txt_v;
        o_push.rec.first    = pre_v ? res_pre : res_txt;
        o_push.rec.second   = res_txt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_esc  <= 8'd0;
            r_oct  <= 2'd0;
            r_hov  <= 1'b0;
            r_len  <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_oct  <= n_oct;
            r_hov  <= n_hov;
            r_len  <= n_len;
        end
    end

endmodule

FILE: hdl/sled_queue.sv
// Small register queue of result records between the front and back ends.
module sled_queue
    import sled_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    // DEPTH must be a power of two of at least two so the pointers wrap.
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full      = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.rec   = r_mem[r_rptr];
    assign do_push     = i_push.valid && !o_full;
    assign do_pop      = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= AW'(r_wptr + 1'b1);
            end
            if (do_pop) begin
                r_rptr <= AW'(r_rptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

FILE: hdl/sled_back.sv
// Back end: unpacks result records into single result beats in an output register.
module sled_back
    import sled_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_head            i_head,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_data_byte,
    output logic [1:0]       o_warning_code,
    output logic             o_input_consumed,
    output logic [LEN_W-1:0] o_string_length,
    output logic             o_last_of_run
);

    logic r_valid, r_phase;
    logic can_load;
    t_res sel;

    assign can_load = !r_valid || !i_stall;
    assign sel      = r_phase ? i_head.rec.second : i_head.rec.first;
    // A record with two results is popped when its second beat is loaded.
    assign o_pop    = can_load && i_head.valid && (r_phase || !i_head.rec.two);
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_head.valid;
            if (i_head.valid) begin
                r_phase          <= i_head.rec.two && !r_phase;
                o_result_kind    <= sel.kind;
                o_data_byte      <= sel.data;
                o_warning_code   <= sel.warn;
                o_string_length  <= sel.len;
                o_input_consumed <= i_head.rec.consumed;
                o_last_of_run    <= r_phase || !i_head.rec.two;
            end
        end
    end

endmodule

FILE: hdl/string_literal_escape_decoder_top.sv
// Top level of the string literal escape decoder.
// One input byte is accepted per clock cycle; the front end updates the escape state in
// that cycle and queues all results the byte causes as one record. The back end delivers
// one result beat per cycle from its output register unless i_stall holds it, so a byte
// that causes two results (a pending escape closed by another byte, or a bad escape before
// end of line) gives two output beats; the record queue of QUEUE_DEPTH entries absorbs
// these, and input is stalled only when it is full. QUEUE_DEPTH must be a power of two,
// at least two. An accepted byte is registered in the queue, then in the output register.
module string_literal_escape_decoder_top
    import sled_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_byte_value,
    input  logic             i_start_string,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_data_byte,
    output logic [1:0]       o_warning_code,
    output logic             o_input_consumed,
    output logic [LEN_W-1:0] o_string_length,
    output logic             o_last_of_run
);

    t_push push;
    t_head head;
    logic  queue_full;
    logic  pop;

    sled_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_start_string (i_start_string),
        .i_queue_full   (queue_full),
        .o_push         (push)
    );

    sled_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (queue_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    sled_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_data_byte      (o_data_byte),
        .o_warning_code   (o_warning_code),
        .o_input_consumed (o_input_consumed),
        .o_string_length  (o_string_length),
        .o_last_of_run    (o_last_of_run)
    );

endmodule

FILE: hdl/sled_checker.sv
// Port-level assertions for the string literal escape decoder, bound to the top level.
module sled_checker
    import sled_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic [7:0]       i_byte_value,
    input logic             i_start_string,
    input logic             o_valid,
    input logic             i_stall,
    input logic [1:0]       o_result_kind,
    input logic [7:0]       o_data_byte,
    input logic [1:0]       o_warning_code,
    input logic             o_input_consumed,
    input logic [LEN_W-1:0] o_string_length,
    input logic             o_last_of_run
);

    // A stalled result beat stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_data_byte)
            && $stable(o_warning_code) && $stable(o_string_length)
            && $stable(o_last_of_run) && $stable(o_input_consumed))
        else $error("stalled result beat changed");

    // Nothing comes out in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // An end result closes the run of its byte and carries no character or warning.
    a_end_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result_kind == KIND_END_QUOTE || o_result_kind == KIND_END_EOL)
            |-> o_last_of_run && o_data_byte == 8'd0 && o_warning_code == WARN_NONE)
        else $error("malformed end result");

    // The beat that follows an accepted beat which is not the last of its run ends that run.
    a_second_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid && o_last_of_run)
        else $error("run not completed by its second result");

endmodule

bind string_literal_escape_decoder_top sled_checker u_sled_checker (.*);

FILE: bench/tb.sv
// Self-checking testbench for the string literal escape decoder.
`timescale 1ns / 1ps

module tb;
    import sled_pkg::*;

    // Decoder modes of the prediction.
    typedef enum logic [2:0] {
        MD_IDLE, MD_TEXT, MD_ESC, MD_OCT, MD_HEX1, MD_HEX, MD_QUOTE
    } t_mode;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [1:0]       warn;
        logic             cons;
        logic [LEN_W-1:0] len;
        logic             last;
    } t_dec_beat;

    // How a stimulus row is checked.
    localparam logic [1:0] ROW_PRED = 2'd0;
    localparam logic [1:0] ROW_NONE = 2'd1;
    localparam logic [1:0] ROW_ONE  = 2'd2;

    typedef struct packed {
        logic [7:0]       b;
        logic             st;
        logic [1:0]       how;
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [1:0]       warn;
        logic [LEN_W-1:0] len;
    } t_row;

    localparam int N_ROWS = 26;
    localparam t_row DIR_TAB [0:N_ROWS-1] = '{
        '{"A",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{8'hFF,        1'b1, ROW_ONE,  KIND_DATA, 8'hFF, WARN_NONE,    16'd1},
        '{CH_BACKSLASH, 1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"q",          1'b0, ROW_ONE,  KIND_DATA, "q",   WARN_UNKNOWN, 16'd2},
        '{CH_BACKSLASH, 1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"3",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"7",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"7",          1'b0, ROW_ONE,  KIND_DATA, 8'hFF, WARN_NONE,    16'd3},
        '{CH_BACKSLASH, 1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"1",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"A",          1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_BACKSLASH, 1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_LOW_X,     1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"G",          1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_BACKSLASH, 1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_LOW_X,     1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"f",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"F",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"f",          1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_DQUOTE,    1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_DQUOTE,    1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"B",          1'b1, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_DQUOTE,    1'b0, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{"Z",          1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_BACKSLASH, 1'b1, ROW_NONE, KIND_DATA, 8'h00, WARN_NONE,    16'd0},
        '{CH_EOL,       1'b0, ROW_PRED, KIND_DATA, 8'h00, WARN_NONE,    16'd0}
    };

    localparam logic [7:0] NAMED_ESC [0:10] = '{
        CH_LOW_A, CH_LOW_B, CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_V,
        CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_byte_value;
    logic             i_start_string;
    logic             o_valid;
    logic             i_stall;
    logic [1:0]       o_result_kind;
    logic [7:0]       o_data_byte;
    logic [1:0]       o_warning_code;
    logic             o_input_consumed;
    logic [LEN_W-1:0] o_string_length;
    logic             o_last_of_run;

    string_literal_escape_decoder_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_byte_value     (i_byte_value),
        .i_start_string   (i_start_string),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_data_byte      (o_data_byte),
        .o_warning_code   (o_warning_code),
        .o_input_consumed (o_input_consumed),
        .o_string_length  (o_string_length),
        .o_last_of_run    (o_last_of_run)
    );

    // Prediction state.
    t_mode            dec_mode;
    logic [7:0]       esc_val;
    logic [1:0]       oct_cnt;
    logic             hex_ovf;
    logic [LEN_W-1:0] dec_len;
    t_dec_beat        out_buf [0:1];
    int               out_n;
    logic             out_cons;

    t_dec_beat  decoded_due [$];
    logic [7:0] str_q [$];
    int         errors;
    int         beats_sent;
    logic       idle_on;
    logic       stall_on;

    always #4 i_clk = ~i_clk;

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_DQUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] data, input logic [1:0] warn);
        if (kind == KIND_DATA && dec_len != 16'hFFFF) dec_len = dec_len + 1'b1;
        out_buf[out_n] = '{kind, data, warn, 1'b0, dec_len, 1'b0};
        out_n++;
    endtask

    task automatic take_text(input logic [7:0] b);
        if (b == CH_EOL) begin
            out_cons = 1'b0;
            emit(KIND_END_EOL, 8'h00, WARN_NONE);
            dec_mode = MD_IDLE;
        end else if (b == CH_DQUOTE) begin
            dec_mode = MD_QUOTE;
        end else if (b == CH_BACKSLASH) begin
            dec_mode = MD_ESC;
        end else begin
            emit(KIND_DATA, b, WARN_NONE);
            dec_mode = MD_TEXT;
        end
    endtask

    task automatic take_escape(input logic [7:0] b);
        dec_mode = MD_TEXT;
        if (b >= "0" && b <= "7") begin
            esc_val = b - "0";
            oct_cnt = 2'd1;
            dec_mode = MD_OCT;
        end else begin
            case (b)
                CH_LOW_X: begin
                    esc_val = 8'h00;
                    hex_ovf = 1'b0;
                    dec_mode = MD_HEX1;
                end
                CH_LOW_A: emit(KIND_DATA, CH_BEL, WARN_NONE);
                CH_LOW_B: emit(KIND_DATA, CH_BS, WARN_NONE);
                CH_LOW_F: emit(KIND_DATA, CH_FF, WARN_NONE);
                CH_LOW_N: emit(KIND_DATA, CH_LF, WARN_NONE);
                CH_LOW_R: emit(KIND_DATA, CH_CR, WARN_NONE);
                CH_LOW_T: emit(KIND_DATA, CH_TAB, WARN_NONE);
                CH_LOW_V: emit(KIND_DATA, CH_VT, WARN_NONE);
                CH_BACKSLASH, CH_DQUOTE, CH_SQUOTE, CH_QMARK: emit(KIND_DATA, b, WARN_NONE);
                default: begin
                    // A backslash right before end of line still ends the string.
                    emit(KIND_DATA, b, WARN_UNKNOWN);
                    if (b == CH_EOL) take_text(CH_EOL);
                end
            endcase
        end
    endtask

    // Works out every result beat that one accepted input byte causes.
    task automatic decode_byte(input logic [7:0] b, input logic st);
        int d;
        out_n = 0;
        out_cons = 1'b1;
        if (st) begin
            esc_val = 8'h00;
            oct_cnt = 2'd0;
            hex_ovf = 1'b0;
            dec_len = '0;
            dec_mode = MD_TEXT;
        end
        d = hex_digit(b);
        case (dec_mode)
            MD_TEXT: take_text(b);
            MD_ESC: take_escape(b);
            MD_OCT: begin
                if (b >= "0" && b <= "7") begin
                    esc_val = 8'(esc_val * 8 + (b - "0"));
                    oct_cnt = oct_cnt + 2'd1;
                    if (oct_cnt == 2'd3) begin
                        emit(KIND_DATA, esc_val, WARN_NONE);
                        dec_mode = MD_TEXT;
                        oct_cnt = 2'd0;
                    end
                end else begin
                    emit(KIND_DATA, esc_val, WARN_NONE);
                    oct_cnt = 2'd0;
                    take_text(b);
                end
            end
            MD_HEX1: begin
                if (d >= 0) begin
                    esc_val = 8'(d);
                    hex_ovf = 1'b0;
                    dec_mode = MD_HEX;
                end else begin
                    emit(KIND_DATA, CH_LOW_X, WARN_NOT_HEX);
                    take_text(b);
                end
            end
            MD_HEX: begin
                if (d >= 0) begin
                    if (esc_val >= 8'd16) hex_ovf = 1'b1;
                    esc_val = {esc_val[3:0], 4'(d)};
                end else begin
                    emit(KIND_DATA, esc_val, hex_ovf ? WARN_HEX_RANGE : WARN_NONE);
                    hex_ovf = 1'b0;
                    take_text(b);
                end
            end
            MD_QUOTE: begin
                if (b == CH_DQUOTE) begin
                    emit(KIND_DATA, CH_DQUOTE, WARN_NONE);
                    dec_mode = MD_TEXT;
                end else begin
                    out_cons = 1'b0;
                    emit(KIND_END_QUOTE, 8'h00, WARN_NONE);
                    dec_mode = MD_IDLE;
                end
            end
            default: dec_mode = MD_IDLE;
        endcase
        for (int k = 0; k < out_n; k++) begin
            out_buf[k].cons = out_cons;
            out_buf[k].last = (k == out_n - 1);
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic st, input logic [1:0] how,
                             input t_dec_beat typed);
        logic ignored;
        if (idle_on) begin
            while ($urandom_range(0, 99) < 17) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_byte_value <= b;
        i_start_string <= st;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        ignored = (dec_mode == MD_IDLE) && !st;
        decode_byte(b, st);
        if (how == ROW_PRED) begin
            for (int k = 0; k < out_n; k++) decoded_due.push_back(out_buf[k]);
        end else if (how == ROW_ONE) begin
            decoded_due.push_back(typed);
        end
        if (!ignored) beats_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (decoded_due.size() != 0);
    endtask

    task automatic add_token();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            str_q.push_back(plain_char());
        end else if (pick < 55) begin
            str_q.push_back(CH_BACKSLASH);
            str_q.push_back(NAMED_ESC[$urandom_range(0, 10)]);
        end else if (pick < 67) begin
            str_q.push_back(CH_BACKSLASH);
            repeat ($urandom_range(1, 3)) str_q.push_back(8'("0" + $urandom_range(0, 7)));
        end else if (pick < 85) begin
            str_q.push_back(CH_BACKSLASH);
            str_q.push_back(CH_LOW_X);
            // A few escapes get no digit at all.
            if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    v = $urandom_range(0, 21);
                    str_q.push_back(8'(v < 10 ? "0" + v : v < 16 ? "a" + v - 10 : "A" + v - 16));
                end
            end
        end else if (pick < 92) begin
            str_q.push_back(CH_BACKSLASH);
            str_q.push_back(8'($urandom_range(1, 255)));
        end else begin
            str_q.push_back(CH_DQUOTE);
            str_q.push_back(CH_DQUOTE);
        end
    endtask

    task automatic random_string();
        int pick;
        str_q.delete();
        repeat ($urandom_range(0, 12)) add_token();
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            str_q.push_back(CH_DQUOTE);
            str_q.push_back(8'($urandom_range(0, 255)));
        end else if (pick < 82) begin
            str_q.push_back(CH_EOL);
        end else if (pick < 90) begin
            str_q.push_back(CH_BACKSLASH);
            str_q.push_back(CH_EOL);
        end
        // Otherwise the string stays open and the next start drops it.
        if (str_q.size() == 0) str_q.push_back(plain_char());
        foreach (str_q[k]) send_beat(str_q[k], k == 0, ROW_PRED, '0);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_dec_beat want;
        i_stall <= stall_on && ($urandom_range(0, 99) < 17);
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (decoded_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d data %0h",
                       o_result_kind, o_data_byte);
                errors++;
            end else begin
                want = decoded_due.pop_front();
                check_field("result_kind", 16'(want.kind), 16'(o_result_kind));
                check_field("data_byte", 16'(want.data), 16'(o_data_byte));
                check_field("warning_code", 16'(want.warn), 16'(o_warning_code));
                check_field("input_consumed", 16'(want.cons), 16'(o_input_consumed));
                check_field("string_length", want.len, o_string_length);
                check_field("last_of_run", 16'(want.last), 16'(o_last_of_run));
            end
        end
    end

    initial begin
        int base_cnt;
        int next_drain;
        logic quiet;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_byte_value = 8'h00;
        i_start_string = 1'b0;
        i_stall = 1'b0;
        errors = 0;
        beats_sent = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        dec_mode = MD_IDLE;
        esc_val = 8'h00;
        oct_cnt = 2'd0;
        hex_ovf = 1'b0;
        dec_len = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TAB[r]) begin
            send_beat(DIR_TAB[r].b, DIR_TAB[r].st, DIR_TAB[r].how,
                      '{DIR_TAB[r].kind, DIR_TAB[r].data, DIR_TAB[r].warn, 1'b1,
                        DIR_TAB[r].len, 1'b1});
        end
        drain_results();

        base_cnt = beats_sent;
        next_drain = base_cnt + 400;
        while (beats_sent - base_cnt < 1900) begin
            quiet = (beats_sent - base_cnt >= 800) && (beats_sent - base_cnt < 1100);
            idle_on = !quiet;
            stall_on = !quiet;
            if (beats_sent >= next_drain) begin
                drain_results();
                next_drain = beats_sent + 400;
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              ROW_PRED, '0);
            end else begin
                random_string();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
